@@ rtl/core/ftd_pkg.sv @@
// ----------------------------------------------------------------------------
// Four-zone threshold detector package
// Zone codes, configuration register indexes, field widths and reset values
// shared by the detector and its channel interfaces.
// ----------------------------------------------------------------------------
package ftd_pkg;

  // Thresholds are 16-bit signed fixed point and the band is 15 bits unsigned.
  localparam int unsigned LevelWidth    = 16;
  localparam int unsigned HystWidth     = 15;
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;
  localparam int unsigned ZoneWidth     = 2;

  typedef enum logic [ZoneWidth-1:0] {
    ZoneLow      = 2'd0,
    ZoneNormal   = 2'd1,
    ZoneHigh     = 2'd2,
    ZoneCritical = 2'd3
  } zone_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    RegLowLevel      = 3'd0,
    RegHighLevel     = 3'd1,
    RegCriticalLevel = 3'd2,
    RegHysteresis    = 3'd3
  } cfg_reg_e;

  typedef logic signed [LevelWidth-1:0] level_t;
  typedef logic        [HystWidth-1:0]  hyst_t;

  localparam level_t LowLevelRst      = 16'shE000;
  localparam level_t HighLevelRst     = 16'sh2000;
  localparam level_t CriticalLevelRst = 16'sh4000;
  localparam hyst_t  HysteresisRst    = 15'd512;

endpackage

@@ rtl/core/ftd_if.sv @@
// ----------------------------------------------------------------------------
// Four-zone threshold detector channel interfaces
// Valid/ready channels for samples, zone results and configuration writes.
// ----------------------------------------------------------------------------
interface ftd_sample_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface ftd_zone_if;
  logic                            valid;
  logic                            ready;
  logic [ftd_pkg::ZoneWidth-1:0]   zone;

  modport source (output valid, output zone, input ready);
  modport sink   (input valid, input zone, output ready);
endinterface

interface ftd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ftd_pkg::CfgIndexWidth-1:0]   index;
  logic [ftd_pkg::CfgDataWidth-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/four_zone_threshold_detector.sv @@
// ----------------------------------------------------------------------------
// Four-zone threshold detector
// The detector takes one signed sample per transfer and reports the zone
// (low, normal, high or critical) that the sample leaves it in, moving between
// zones with strict compares against programmable levels and a hysteresis
// band. It accepts one sample every clock cycle unless a stalled result holds
// the sample register full. Each result passes through the sample register and
// then the zone register, which is both the state and the result. A stalled
// result does not stop the next sample entering an empty sample register, and
// samples keep flowing at full rate whenever the result side takes a transfer
// every cycle. Configuration writes are accepted at any time but must only be
// issued while no sample is in flight; the zone starts at normal after reset.
// ----------------------------------------------------------------------------
module four_zone_threshold_detector #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ftd_sample_if.sink  sample_i,
  ftd_zone_if.source  zone_o,
  ftd_cfg_if.sink     cfg_i
);
  import ftd_pkg::*;

  // All compares are done at a width that holds any sample, any level and a
  // level plus or minus the band, so no sum can wrap.
  localparam int unsigned CmpWidth =
      ((SAMPLE_WIDTH > LevelWidth) ? SAMPLE_WIDTH : LevelWidth) + 2;

  // Configuration registers.
  level_t low_level_q, high_level_q, critical_level_q;
  hyst_t  hysteresis_q;

  // Sample stage.
  logic                           s1_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample_q;

  // Zone register: holds the current zone and doubles as the result payload.
  zone_e zone_q, zone_d;
  logic  out_valid_q;

  logic out_free;
  logic s1_advance;
  logic sample_xfer;

  logic signed [CmpWidth-1:0] smp_ext, lo_ext, hi_ext, cr_ext, hy_ext;
  logic signed [CmpWidth-1:0] lo_plus_hy, hi_minus_hy, cr_minus_hy;

  // The result register is free when empty or when its result transfers now.
  assign out_free    = !out_valid_q || zone_o.ready;
  assign s1_advance  = s1_valid_q && out_free;
  assign sample_i.ready = !s1_valid_q || out_free;
  assign sample_xfer = sample_i.valid && sample_i.ready;

  assign zone_o.valid = out_valid_q;
  assign zone_o.zone  = zone_q;

  // Configuration is always taken; an unknown index is dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_level_q      <= LowLevelRst;
      high_level_q     <= HighLevelRst;
      critical_level_q <= CriticalLevelRst;
      hysteresis_q     <= HysteresisRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegLowLevel:      low_level_q      <= level_t'(cfg_i.data);
        RegHighLevel:     high_level_q     <= level_t'(cfg_i.data);
        RegCriticalLevel: critical_level_q <= level_t'(cfg_i.data);
        RegHysteresis:    hysteresis_q     <= cfg_i.data[HystWidth-1:0];
        default: ;
      endcase
    end
  end

  // Sample register: control state is reset, the payload is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      s1_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_xfer) begin
      s1_sample_q <= sample_i.sample;
    end
  end

  // Sign-extend everything to the compare width; the band is unsigned.
  assign smp_ext = CmpWidth'(s1_sample_q);
  assign lo_ext  = CmpWidth'(low_level_q);
  assign hi_ext  = CmpWidth'(high_level_q);
  assign cr_ext  = CmpWidth'(critical_level_q);
  assign hy_ext  = signed'({{(CmpWidth - HystWidth){1'b0}}, hysteresis_q});

  assign lo_plus_hy  = lo_ext + hy_ext;
  assign hi_minus_hy = hi_ext - hy_ext;
  assign cr_minus_hy = cr_ext - hy_ext;

  // Zone transitions. Every compare is strict, so a sample that equals a
  // bound leaves the zone where it is. From normal, the low check wins when
  // the levels are out of order and both would fire.
  always_comb begin
    zone_d = zone_q;
    case (zone_q)
      ZoneLow: begin
        if (smp_ext > lo_plus_hy) zone_d = ZoneNormal;
      end
      ZoneNormal: begin
        if (smp_ext < lo_ext) begin
          zone_d = ZoneLow;
        end else if (smp_ext > hi_ext) begin
          zone_d = ZoneHigh;
        end
      end
      ZoneHigh: begin
        if (smp_ext > cr_ext) begin
          zone_d = ZoneCritical;
        end else if (smp_ext < hi_minus_hy) begin
          zone_d = ZoneNormal;
        end
      end
      ZoneCritical: begin
        if (smp_ext < cr_minus_hy) zone_d = ZoneHigh;
      end
      default: zone_d = ZoneNormal;
    endcase
  end

  // The zone register moves only when a sample leaves the sample stage, so
  // each sample sees the zone that the one before it left behind.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q      <= ZoneNormal;
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        zone_q <= zone_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The zone never changes without a sample passing into the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_advance |=> $stable(zone_q))
    else $error("zone changed without a sample advancing");

  // A new result appears only from a sample that was waiting in the stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result became valid without a pending sample");

  // Low can only be left toward normal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    zone_q == ZoneLow |=> (zone_q == ZoneLow || zone_q == ZoneNormal))
    else $error("illegal transition out of the low zone");

  // Critical can only be left toward high.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    zone_q == ZoneCritical |=> (zone_q == ZoneCritical || zone_q == ZoneHigh))
    else $error("illegal transition out of the critical zone");
`endif

endmodule
